// ===== src/fmv_pkg.sv =====
// Shared constants for the framed message verifier: parse phases, reasons, layout sizes.
package fmv_pkg;

   // Parse phases
   localparam logic [2:0] PHASE_HLEN   = 3'd0;
   localparam logic [2:0] PHASE_TOTAL  = 3'd1;
   localparam logic [2:0] PHASE_KIND   = 3'd2;
   localparam logic [2:0] PHASE_HEADER = 3'd3;
   localparam logic [2:0] PHASE_MAGIC1 = 3'd4;
   localparam logic [2:0] PHASE_BLEN   = 3'd5;
   localparam logic [2:0] PHASE_BDATA  = 3'd6;
   localparam logic [2:0] PHASE_TAIL   = 3'd7;

   // Error reasons, reported in priority order short, length, header, kind, blobs, magic, sum
   localparam logic [2:0] REASON_OK       = 3'd0;
   localparam logic [2:0] REASON_LENGTH   = 3'd1;
   localparam logic [2:0] REASON_HEADER   = 3'd2;
   localparam logic [2:0] REASON_KIND     = 3'd3;
   localparam logic [2:0] REASON_BLOBS    = 3'd4;
   localparam logic [2:0] REASON_MAGIC    = 3'd5;
   localparam logic [2:0] REASON_CHECKSUM = 3'd6;
   localparam logic [2:0] REASON_SHORT    = 3'd7;

   // Layout sizes
   localparam int unsigned FIXED_WORDS_LEN = 12;
   localparam int unsigned MAGIC_PAIR_LEN  = 8;

   localparam logic [31:0] MAX_KIND_RESET = 32'd255;
   localparam logic [29:0] TALLY_MAX      = 30'h3FFF_FFFF;
   localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;

endpackage

// ===== src/framed_message_verifier.sv =====
// Framed message verifier: byte-serial framing, length, magic and checksum checks.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall | req_data_byte, req_last_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_valid_res, rsp_error_reason,
//           |           |                     | rsp_message_kind, rsp_blob_count
//   csr     | in        | csr_write_enable    | csr_write_data (max message kind)
//
// One byte is taken every cycle while req_stall is low; the parse state updates at the accepting edge.
// The result of a message appears in the output register in the cycle after its last byte is accepted.
// req_stall is high only while a result is held in the output register under rsp_stall.
// Synchronous reset clears the message state, empties the output register and sets the
// max message kind to 255.
module framed_message_verifier
   import fmv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [2:0]  rsp_error_reason,
   output logic [31:0] rsp_message_kind,
   output logic [29:0] rsp_blob_count,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   // Message state
   logic [31:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] field_ff, field_in;
   logic [31:0] hlen_ff, hlen_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] kind_ff, kind_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] xor_ff, xor_in;
   logic [31:0] blob_end_ff, blob_end_in;
   logic [29:0] tally_ff, tally_in;
   logic        blob_err_ff, blob_err_in;
   logic [31:0] max_kind_ff;

   // Output register
   logic        rsp_valid_ff;
   logic        rsp_res_ff;
   logic [2:0]  rsp_reason_ff;
   logic [31:0] rsp_kind_ff;
   logic [29:0] rsp_count_ff;

   logic        accept;
   logic        out_free;
   logic [32:0] pos_x;
   logic [32:0] n_x;
   logic [32:0] m1_x;
   logic [33:0] m1_end_x;
   logic [33:0] m1_pair_x;
   logic [33:0] blob_e_x;
   logic [33:0] blob_e4_x;
   logic [33:0] total_x;
   logic [29:0] tally_inc;
   logic [2:0]  reason;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   // Wide offsets used by the phase checks
   assign pos_x     = {1'b0, pos_ff};
   assign n_x       = pos_x + 33'd1;
   assign m1_x      = {1'b0, hlen_ff} + 33'(FIXED_WORDS_LEN);
   assign m1_end_x  = {1'b0, m1_x} + 34'd3;
   assign m1_pair_x = {1'b0, m1_x} + 34'(MAGIC_PAIR_LEN);
   assign blob_e_x  = {2'b0, field_in} + {2'b0, blob_end_ff} + 34'd4;
   assign blob_e4_x = {2'b0, field_in} + {2'b0, blob_end_ff} + 34'd8;
   assign total_x   = {2'b0, total_ff};
   assign tally_inc = (tally_ff < TALLY_MAX) ? tally_ff + 30'd1 : tally_ff;

   // Advance the parse state for one byte
   always_comb begin
      pos_in      = (pos_ff < POS_MAX) ? pos_ff + 32'd1 : pos_ff;
      phase_in    = phase_ff;
      field_in    = {req_data_byte, field_ff[31:8]};
      hlen_in     = hlen_ff;
      total_in    = total_ff;
      kind_in     = kind_ff;
      magic_in    = magic_ff;
      xor_in      = xor_ff;
      blob_end_in = blob_end_ff;
      tally_in    = tally_ff;
      blob_err_in = blob_err_ff;

      // fold the byte into its lane, skipping the magic words
      if (phase_ff != PHASE_MAGIC1 && phase_ff != PHASE_TAIL) begin
         case (pos_ff[1:0])
            2'd0:    xor_in = xor_ff ^ {24'd0, req_data_byte};
            2'd1:    xor_in = xor_ff ^ {16'd0, req_data_byte, 8'd0};
            2'd2:    xor_in = xor_ff ^ {8'd0, req_data_byte, 16'd0};
            default: xor_in = xor_ff ^ {req_data_byte, 24'd0};
         endcase
      end

      unique case (phase_ff)
         PHASE_HLEN: begin
            if (pos_ff == 32'd3) begin
               hlen_in  = field_in;
               phase_in = PHASE_TOTAL;
            end
         end
         PHASE_TOTAL: begin
            if (pos_ff == 32'd7) begin
               total_in = field_in;
               phase_in = PHASE_KIND;
            end
         end
         PHASE_KIND: begin
            if (pos_ff == 32'd11) begin
               kind_in  = field_in;
               phase_in = (hlen_ff == 32'd0) ? PHASE_MAGIC1 : PHASE_HEADER;
            end
         end
         PHASE_HEADER: begin
            if (n_x == m1_x) phase_in = PHASE_MAGIC1;
         end
         PHASE_MAGIC1: begin
            if ({1'b0, pos_x} == m1_end_x) begin
               magic_in = field_in;
               if (m1_pair_x == total_x) begin
                  phase_in = PHASE_TAIL;
               end else if (m1_pair_x < total_x) begin
                  blob_end_in = m1_x[31:0] + 32'd4;
                  tally_in    = 30'd1;
                  phase_in    = PHASE_BLEN;
               end else begin
                  blob_err_in = 1'b1;
                  phase_in    = PHASE_TAIL;
               end
            end
         end
         PHASE_BLEN: begin
            if ({1'b0, blob_end_ff} + 33'd3 == pos_x) begin
               if (blob_e4_x < total_x) begin
                  tally_in    = tally_inc;
                  blob_end_in = blob_e_x[31:0];
                  phase_in    = (blob_e_x == {1'b0, n_x}) ? PHASE_BLEN : PHASE_BDATA;
               end else if (blob_e4_x == total_x) begin
                  blob_end_in = blob_e_x[31:0];
                  phase_in    = (blob_e_x == {1'b0, n_x}) ? PHASE_TAIL : PHASE_BDATA;
               end else begin
                  blob_err_in = 1'b1;
                  phase_in    = PHASE_TAIL;
               end
            end
         end
         PHASE_BDATA: begin
            if (n_x == {1'b0, blob_end_ff}) begin
               phase_in = ({1'b0, blob_end_ff} + 33'd4 == total_x[32:0]) ? PHASE_TAIL
                                                                          : PHASE_BLEN;
            end
         end
         default: begin
         end
      endcase
   end

   // Pick the first failing check for the message that ends with this byte
   always_comb begin
      if (pos_ff < 32'd11)                     reason = REASON_SHORT;
      else if ({1'b0, total_ff} != n_x)        reason = REASON_LENGTH;
      else if ({1'b0, hlen_in} > n_x)          reason = REASON_HEADER;
      else if (kind_in > max_kind_ff)          reason = REASON_KIND;
      else if (blob_err_in || phase_in != PHASE_TAIL) reason = REASON_BLOBS;
      else if (magic_in != field_in)           reason = REASON_MAGIC;
      else if (xor_in != magic_in)             reason = REASON_CHECKSUM;
      else                                     reason = REASON_OK;
   end

   // Hold the message state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff      <= '0;
         phase_ff    <= PHASE_HLEN;
         field_ff    <= '0;
         hlen_ff     <= '0;
         total_ff    <= '0;
         kind_ff     <= '0;
         magic_ff    <= '0;
         xor_ff      <= '0;
         blob_end_ff <= '0;
         tally_ff    <= '0;
         blob_err_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         field_ff    <= field_in;
         hlen_ff     <= hlen_in;
         total_ff    <= total_in;
         kind_ff     <= kind_in;
         magic_ff    <= magic_in;
         xor_ff      <= xor_in;
         blob_end_ff <= blob_end_in;
         tally_ff    <= tally_in;
         blob_err_ff <= blob_err_in;
      end
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_kind_ff <= MAX_KIND_RESET;
      end else if (csr_write_enable) begin
         max_kind_ff <= csr_write_data;
      end
   end

   // Load the result register on the last byte; drop the item once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= accept && req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         rsp_res_ff    <= (reason == REASON_OK);
         rsp_reason_ff <= reason;
         rsp_kind_ff   <= kind_in;
         rsp_count_ff  <= tally_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valid_res    = rsp_res_ff;
   assign rsp_error_reason = rsp_reason_ff;
   assign rsp_message_kind = rsp_kind_ff;
   assign rsp_blob_count   = rsp_count_ff;

   // Checks on the block's own logic
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> rsp_valid)
      else $error("last byte accepted without a result");

   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> pos_ff == 32'd0 && phase_ff == PHASE_HLEN)
      else $error("message state not cleared after last byte");

   a_result_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_res == (rsp_error_reason == REASON_OK))
      else $error("valid flag disagrees with reason");

   a_tally_early: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_HLEN || phase_ff == PHASE_TOTAL || phase_ff == PHASE_KIND ||
      phase_ff == PHASE_HEADER || phase_ff == PHASE_MAGIC1 |-> tally_ff == 30'd0)
      else $error("blob count set before the blob chain");

endmodule
